### design/rrgf_pkg.sv
package rrgf_pkg;

   // pixel coordinate width and a signed width that holds a coordinate plus a size
   localparam int COORD_BITS = 16;
   localparam int SIZE_BITS  = 15;
   localparam int EXT_BITS   = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;
   localparam int RAD_BITS   = 14;
   localparam int SQ_BITS    = 2 * RAD_BITS;
   localparam int SURF_BITS  = 16;
   localparam int CHAN_BITS  = 8;
   localparam int NUM_CHAN   = 3;
   localparam int COLOR_BITS = NUM_CHAN * CHAN_BITS;
   localparam int MAG_BITS   = CHAN_BITS + SIZE_BITS;
   localparam int QIDX_BITS  = $clog2(CHAN_BITS);

   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;

   // pipeline layout
   localparam int DIV_STAGES   = 4;
   localparam int DIV_STEPS    = CHAN_BITS / DIV_STAGES;
   localparam int STG_IN       = 0;
   localparam int STG_CMP      = 1;
   localparam int STG_MUL      = 2;
   localparam int STG_DIV      = 3;
   localparam int FRONT_STAGES = STG_DIV;
   localparam int NUM_STAGES   = STG_DIV + DIV_STAGES + 1;
   localparam int STG_OUT      = NUM_STAGES - 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RECT_X,
      CSR_RECT_Y,
      CSR_RECT_WIDTH,
      CSR_RECT_HEIGHT,
      CSR_CORNER_RADIUS,
      CSR_TOP_COLOR,
      CSR_BOTTOM_COLOR,
      CSR_SURFACE_SIZE
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pixel_x;
      logic signed [COORD_BITS-1:0] pixel_y;
   } req_type;

   typedef struct packed {
      logic                         draw;
      logic [COLOR_BITS-1:0]        out_color;
      logic signed [COORD_BITS-1:0] out_x;
      logic signed [COORD_BITS-1:0] out_y;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]         x0;
      logic signed [COORD_BITS-1:0]         y0;
      logic signed [EXT_BITS-1:0]           x_end;
      logic signed [EXT_BITS-1:0]           y_end;
      logic signed [EXT_BITS-1:0]           x_left;
      logic signed [EXT_BITS-1:0]           x_right;
      logic signed [EXT_BITS-1:0]           cx_right;
      logic signed [EXT_BITS-1:0]           y_top;
      logic signed [EXT_BITS-1:0]           y_bot;
      logic signed [EXT_BITS-1:0]           cy_bot;
      logic [SURF_BITS-1:0]                 surf_w;
      logic [SURF_BITS-1:0]                 surf_h;
      logic                                 nonempty;
      logic [SQ_BITS-1:0]                   rad_sq;
      logic [SIZE_BITS-1:0]                 div_n;
      logic                                 short_h;
      logic [COLOR_BITS-1:0]                top_color;
      logic [NUM_CHAN-1:0][CHAN_BITS-1:0]   chan_top;
      logic [NUM_CHAN-1:0][CHAN_BITS-1:0]   diff_mag;
      logic [NUM_CHAN-1:0]                  diff_neg;
   } cfg_type;

   typedef struct packed {
      logic                         base;
      logic                         corner;
      logic [RAD_BITS-1:0]          adx;
      logic [RAD_BITS-1:0]          ady;
      logic [SIZE_BITS-1:0]         row;
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
   } s1_type;

   typedef struct packed {
      logic                               base;
      logic                               corner;
      logic [SQ_BITS-1:0]                 sq_x;
      logic [SQ_BITS-1:0]                 sq_y;
      logic [NUM_CHAN-1:0][MAG_BITS-1:0]  mag;
      logic signed [COORD_BITS-1:0]       px;
      logic signed [COORD_BITS-1:0]       py;
   } s2_type;

   typedef struct packed {
      logic                         hit;
      logic signed [COORD_BITS-1:0] px;
      logic signed [COORD_BITS-1:0] py;
   } side_type;

   typedef struct packed {
      logic [MAG_BITS-1:0]  rem;
      logic [CHAN_BITS-1:0] quo;
   } div_type;

   // one restoring step: quotient bit k
   function automatic div_type div_step(div_type d, logic [SIZE_BITS-1:0] n,
                                        logic [QIDX_BITS-1:0] k);
      logic [MAG_BITS-1:0] sub;
      div_type             r;
      sub = MAG_BITS'(n) << k;
      r   = d;
      if (d.rem >= sub) begin
         r.rem    = d.rem - sub;
         r.quo[k] = 1'b1;
      end
      return r;
   endfunction

   // the steps done in one pipeline stage, highest quotient bit first
   function automatic div_type div_stage(div_type d, logic [SIZE_BITS-1:0] n,
                                         logic [QIDX_BITS-1:0] top_k);
      div_type r;
      r = d;
      for (int j = 0; j < DIV_STEPS; j++) begin
         r = div_step(r, n, top_k - QIDX_BITS'(j));
      end
      return r;
   endfunction

endpackage

### design/rounded_rect_gradient_fill.sv
// rounded rectangle fill with a vertical colour gradient, one pixel per transaction
//
// req channel: a pixel coordinate (req_valid / req_stall, accepted when valid and not
// stalled). rsp channel: draw flag, colour and the echoed coordinate, one result per
// request, in request order. csr port: single-cycle register writes, no read-back;
// the user must see that registers are written only while the pipe is empty; the block does not enforce it.
//
// eight register stages: input, bounds and corner compare, squares and colour
// products, four stages of a restoring divider (two quotient bits each), output.
// one pixel per clock is sustained while rsp_stall is low; the per-channel divide
// by height minus one sets the depth.
//
// rsp_stall holds the output register; earlier stages keep filling until each is
// occupied, so bubbles are squeezed out and nothing is dropped or repeated.
// req_stall is high in reset or while the first stage is occupied and cannot move on.
//
// synchronous reset clears the configuration registers to zero and empties the pipe;
// no request is taken while reset is high.
module rounded_rect_gradient_fill (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  rrgf_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output rrgf_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wen,
   input  logic [rrgf_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [rrgf_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import rrgf_pkg::*;

   cfg_type                            cfg;
   logic [NUM_STAGES-1:0]              stage_en;
   s2_type                             s2;
   logic [NUM_CHAN-1:0][CHAN_BITS-1:0] quo;
   logic [SQ_BITS:0]                   dist_sq;

   side_type side_in;
   side_type side_ff [DIV_STAGES];
   rsp_type  rsp_in, rsp_ff;

   // configuration registers plus values derived from them
   rrgf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // per-stage valid bits and load enables
   rrgf_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .stage_en  (stage_en)
   );

   // input register, geometry tests, squares and gradient products
   rrgf_front u_front (
      .clock    (clock),
      .stage_en (stage_en[FRONT_STAGES-1:0]),
      .cfg      (cfg),
      .req_data (req_data),
      .s2_data  (s2)
   );

   // one divider per colour channel: |bottom - top| * row / (height - 1)
   for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
      rrgf_div_lane u_div (
         .clock    (clock),
         .stage_en (stage_en[STG_DIV +: DIV_STAGES]),
         .mag      (s2.mag[c]),
         .div_n    (cfg.div_n),
         .quo      (quo[c])
      );
   end

   // corner circle test, resolved alongside the first divider stage
   assign dist_sq = {1'b0, s2.sq_x} + {1'b0, s2.sq_y};

   always_comb begin
      side_in.hit = s2.base && (!s2.corner || (dist_sq <= {1'b0, cfg.rad_sq}));
      side_in.px  = s2.px;
      side_in.py  = s2.py;
   end

   // output stage: signed blend per channel, short rectangles take the top colour,
   // undrawn pixels report black
   always_comb begin
      side_type                           last;
      logic [NUM_CHAN-1:0][CHAN_BITS-1:0] blend;
      last = side_ff[DIV_STAGES-1];
      for (int c = 0; c < NUM_CHAN; c++) begin
         blend[c] = cfg.diff_neg[c] ? cfg.chan_top[c] - quo[c] : cfg.chan_top[c] + quo[c];
      end
      rsp_in.draw = last.hit;
      if (!last.hit) begin
         rsp_in.out_color = '0;
      end else if (cfg.short_h) begin
         rsp_in.out_color = cfg.top_color;
      end else begin
         rsp_in.out_color = blend;
      end
      rsp_in.out_x = last.px;
      rsp_in.out_y = last.py;
   end

   // draw flag and coordinates ride along with the divider stages
   always_ff @(posedge clock) begin
      if (stage_en[STG_DIV]) begin
         side_ff[0] <= side_in;
      end
      for (int i = 1; i < DIV_STAGES; i++) begin
         if (stage_en[STG_DIV + i]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
      if (stage_en[STG_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### design/rrgf_csr.sv
module rrgf_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wen,
   input  logic [rrgf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rrgf_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output rrgf_pkg::cfg_type                     cfg
);
   import rrgf_pkg::*;

   logic [COORD_BITS-1:0]    rect_x_ff, rect_x_in;
   logic [COORD_BITS-1:0]    rect_y_ff, rect_y_in;
   logic [SIZE_BITS-1:0]     rect_w_ff, rect_w_in;
   logic [SIZE_BITS-1:0]     rect_h_ff, rect_h_in;
   logic [RAD_BITS-1:0]      radius_ff, radius_in;
   logic [COLOR_BITS-1:0]    top_ff, top_in;
   logic [COLOR_BITS-1:0]    bot_ff, bot_in;
   logic [CSR_DATA_BITS-1:0] surf_ff, surf_in;

   logic [RAD_BITS-1:0]      rad_ff, rad_in;
   cfg_type                  cfg_ff, cfg_in;

   logic [RAD_BITS-1:0]        half_w, half_h, rad_w;
   logic signed [EXT_BITS-1:0] x_e, y_e, w_e, h_e, r_e;
   logic [NUM_CHAN-1:0][CHAN_BITS-1:0] ca, cb;

   always_comb begin
      rect_x_in = rect_x_ff;
      rect_y_in = rect_y_ff;
      rect_w_in = rect_w_ff;
      rect_h_in = rect_h_ff;
      radius_in = radius_ff;
      top_in    = top_ff;
      bot_in    = bot_ff;
      surf_in   = surf_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_RECT_X:        rect_x_in = csr_wdata[COORD_BITS-1:0];
            CSR_RECT_Y:        rect_y_in = csr_wdata[COORD_BITS-1:0];
            CSR_RECT_WIDTH:    rect_w_in = csr_wdata[SIZE_BITS-1:0];
            CSR_RECT_HEIGHT:   rect_h_in = csr_wdata[SIZE_BITS-1:0];
            CSR_CORNER_RADIUS: radius_in = csr_wdata[RAD_BITS-1:0];
            CSR_TOP_COLOR:     top_in    = csr_wdata[COLOR_BITS-1:0];
            CSR_BOTTOM_COLOR:  bot_in    = csr_wdata[COLOR_BITS-1:0];
            CSR_SURFACE_SIZE:  surf_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // radius clamp to half width, then half height
   assign half_w = rect_w_ff[SIZE_BITS-1:1];
   assign half_h = rect_h_ff[SIZE_BITS-1:1];
   assign rad_w  = (radius_ff > half_w) ? half_w : radius_ff;
   assign rad_in = (rad_w > half_h) ? half_h : rad_w;

   assign x_e = EXT_BITS'($signed(rect_x_ff));
   assign y_e = EXT_BITS'($signed(rect_y_ff));
   assign w_e = EXT_BITS'(rect_w_ff);
   assign h_e = EXT_BITS'(rect_h_ff);
   assign r_e = EXT_BITS'(rad_in);
   assign ca  = top_ff;
   assign cb  = bot_ff;

   always_comb begin
      cfg_in.x0        = rect_x_ff;
      cfg_in.y0        = rect_y_ff;
      cfg_in.x_end     = x_e + w_e;
      cfg_in.y_end     = y_e + h_e;
      cfg_in.x_left    = x_e + r_e;
      cfg_in.x_right   = x_e + w_e - r_e;
      cfg_in.cx_right  = x_e + w_e + ~r_e;
      cfg_in.y_top     = y_e + r_e;
      cfg_in.y_bot     = y_e + h_e - r_e;
      cfg_in.cy_bot    = y_e + h_e + ~r_e;
      cfg_in.surf_w    = surf_ff[2*SURF_BITS-1:SURF_BITS];
      cfg_in.surf_h    = surf_ff[SURF_BITS-1:0];
      cfg_in.nonempty  = (rect_w_ff != '0) && (rect_h_ff != '0);
      // squared radius from the registered clamp, so it lags the other derived values
      cfg_in.rad_sq    = SQ_BITS'(rad_ff) * SQ_BITS'(rad_ff);
      cfg_in.div_n     = rect_h_ff - SIZE_BITS'(1);
      cfg_in.short_h   = rect_h_ff <= SIZE_BITS'(2);
      cfg_in.top_color = top_ff;
      cfg_in.chan_top  = ca;
      for (int c = 0; c < NUM_CHAN; c++) begin
         cfg_in.diff_neg[c] = cb[c] < ca[c];
         cfg_in.diff_mag[c] = (cb[c] < ca[c]) ? ca[c] - cb[c] : cb[c] - ca[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_x_ff <= '0;
         rect_y_ff <= '0;
         rect_w_ff <= '0;
         rect_h_ff <= '0;
         radius_ff <= '0;
         top_ff    <= '0;
         bot_ff    <= '0;
         surf_ff   <= '0;
      end else begin
         rect_x_ff <= rect_x_in;
         rect_y_ff <= rect_y_in;
         rect_w_ff <= rect_w_in;
         rect_h_ff <= rect_h_in;
         radius_ff <= radius_in;
         top_ff    <= top_in;
         bot_ff    <= bot_in;
         surf_ff   <= surf_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

### design/rrgf_flow.sv
module rrgf_flow (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             rsp_stall,
   output logic                             req_stall,
   output logic                             rsp_valid,
   output logic [rrgf_pkg::NUM_STAGES-1:0]  stage_en
);
   import rrgf_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff, valid_in, upstream;

   // a stage may load when it is empty or its transaction moves on
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
   end

   assign upstream = {valid_ff[NUM_STAGES-2:0], req_valid};
   assign valid_in = (stage_en & upstream) | (~stage_en & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = reset || !stage_en[STG_IN];
   assign rsp_valid = valid_ff[STG_OUT];

endmodule

### design/rrgf_front.sv
module rrgf_front (
   input  logic                                clock,
   input  logic [rrgf_pkg::FRONT_STAGES-1:0]   stage_en,
   input  rrgf_pkg::cfg_type                   cfg,
   input  rrgf_pkg::req_type                   req_data,
   output rrgf_pkg::s2_type                    s2_data
);
   import rrgf_pkg::*;

   req_type s0_ff;
   s1_type  s1_in, s1_ff;
   s2_type  s2_in, s2_ff;

   logic signed [EXT_BITS-1:0] px_e, py_e, x_e, y_e, sw_e, sh_e;
   logic signed [EXT_BITS-1:0] dx_l, dx_r, dy_t, dy_b, row_e;
   logic on_surf, in_rect, at_left, at_right, at_top, at_bot;

   assign px_e = EXT_BITS'($signed(s0_ff.pixel_x));
   assign py_e = EXT_BITS'($signed(s0_ff.pixel_y));
   assign x_e  = EXT_BITS'($signed(cfg.x0));
   assign y_e  = EXT_BITS'($signed(cfg.y0));
   assign sw_e = EXT_BITS'(cfg.surf_w);
   assign sh_e = EXT_BITS'(cfg.surf_h);

   assign on_surf = !px_e[EXT_BITS-1] && !py_e[EXT_BITS-1] && (px_e < sw_e) && (py_e < sh_e);
   assign in_rect = cfg.nonempty && (px_e >= x_e) && (px_e < cfg.x_end)
                    && (py_e >= y_e) && (py_e < cfg.y_end);

   // corner squares; left and right cannot both hold once the radius is clamped
   assign at_left  = px_e < cfg.x_left;
   assign at_right = px_e >= cfg.x_right;
   assign at_top   = py_e < cfg.y_top;
   assign at_bot   = py_e >= cfg.y_bot;

   assign dx_l  = cfg.x_left - px_e;
   assign dx_r  = px_e - cfg.cx_right;
   assign dy_t  = cfg.y_top - py_e;
   assign dy_b  = py_e - cfg.cy_bot;
   assign row_e = py_e - y_e;

   always_comb begin
      s1_in.base   = on_surf && in_rect;
      s1_in.corner = (at_left || at_right) && (at_top || at_bot);
      s1_in.adx    = at_left ? dx_l[RAD_BITS-1:0] : dx_r[RAD_BITS-1:0];
      s1_in.ady    = at_top ? dy_t[RAD_BITS-1:0] : dy_b[RAD_BITS-1:0];
      s1_in.row    = row_e[SIZE_BITS-1:0];
      s1_in.px     = s0_ff.pixel_x;
      s1_in.py     = s0_ff.pixel_y;
   end

   always_comb begin
      s2_in.base   = s1_ff.base;
      s2_in.corner = s1_ff.corner;
      s2_in.sq_x   = SQ_BITS'(s1_ff.adx) * SQ_BITS'(s1_ff.adx);
      s2_in.sq_y   = SQ_BITS'(s1_ff.ady) * SQ_BITS'(s1_ff.ady);
      for (int c = 0; c < NUM_CHAN; c++) begin
         s2_in.mag[c] = MAG_BITS'(cfg.diff_mag[c]) * MAG_BITS'(s1_ff.row);
      end
      s2_in.px     = s1_ff.px;
      s2_in.py     = s1_ff.py;
   end

   always_ff @(posedge clock) begin
      if (stage_en[STG_IN]) begin
         s0_ff <= req_data;
      end
      if (stage_en[STG_CMP]) begin
         s1_ff <= s1_in;
      end
      if (stage_en[STG_MUL]) begin
         s2_ff <= s2_in;
      end
   end

   assign s2_data = s2_ff;

endmodule

### design/rrgf_div_lane.sv
module rrgf_div_lane (
   input  logic                               clock,
   input  logic [rrgf_pkg::DIV_STAGES-1:0]    stage_en,
   input  logic [rrgf_pkg::MAG_BITS-1:0]      mag,
   input  logic [rrgf_pkg::SIZE_BITS-1:0]     div_n,
   output logic [rrgf_pkg::CHAN_BITS-1:0]     quo
);
   import rrgf_pkg::*;

   div_type stage_src [DIV_STAGES];
   div_type stage_in  [DIV_STAGES];
   div_type stage_ff  [DIV_STAGES];

   // quotient never exceeds one channel's range, so only its low bits are worked out
   assign stage_src[0] = '{rem: mag, quo: '0};

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s > 0) begin : g_link
         assign stage_src[s] = stage_ff[s-1];
      end
      assign stage_in[s] = div_stage(stage_src[s], div_n,
                                     QIDX_BITS'(CHAN_BITS - 1 - s * DIV_STEPS));
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (stage_en[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign quo = stage_ff[DIV_STAGES-1].quo;

endmodule
